### src/pc_sample_profiler_macros.svh
// Assertion macros used by the profiler controller.
`ifndef PC_SAMPLE_PROFILER_MACROS_SVH
`define PC_SAMPLE_PROFILER_MACROS_SVH

// Same-cycle implication, held off during reset.
`define PCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pcs_pkg.sv
// Types, codes and constants of the pc sample profiler.
package pcs_pkg;

  localparam int SLOT_DEPTH = 1024;
  localparam int SLOT_W     = 10;
  localparam int IDX_W      = 11;
  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 32;
  localparam int DIV_STEPS  = 32;
  localparam int DCNT_W     = 6;
  localparam int PADDR_W    = 5;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_ADD     = 3'd1,
    CMD_CLR_CNT = 3'd2,
    CMD_CLR_SYM = 3'd3,
    CMD_READ    = 3'd4
  } pcs_code_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_IGNORED = 3'd1,
    ST_RANGE   = 3'd2,
    ST_FULL    = 3'd3,
    ST_DUP     = 3'd4
  } pcs_status_t;

  typedef enum logic [2:0] {
    REG_ENABLE  = 3'd0,
    REG_LINK    = 3'd1,
    REG_USE_SYM = 3'd2,
    REG_WSTART  = 3'd3,
    REG_WEND    = 3'd4,
    REG_BUCKET  = 3'd5
  } pcs_reg_t;

  typedef struct packed {
    logic [2:0]        command;
    logic [31:0]       sample_pc;
    logic [31:0]       sample_return;
    logic [7:0]        tick_count;
    logic              core_busy;
    logic [31:0]       symbol_address;
    logic [SLOT_W-1:0] slot_index;
  } pcs_in_t;

  typedef struct packed {
    pcs_status_t       status;
    logic [SLOT_W-1:0] slot_used;
    logic [31:0]       hit_value;
    logic [31:0]       slot_address;
    logic [31:0]       total_ticks;
    logic [IDX_W-1:0]  symbol_count;
  } pcs_out_t;

  typedef struct packed {
    logic        enable;
    logic        sample_link;
    logic        use_symbols;
    logic [31:0] window_start;
    logic [31:0] window_end;
    logic [31:0] bucket_bytes;
  } pcs_cfg_t;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DECODE, S_SRCH, S_SRCH_CMP, S_DIV, S_CNT_RD, S_CNT_WR,
    S_SLOT_RD, S_SLOT_FIN, S_DUP_RD, S_DUP_CMP, S_SHIFT, S_SHIFT_WR, S_INS,
    S_CLR, S_FIN
  } pcs_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_DECODE, OP_SWEEP, OP_SRCH_RD, OP_SRCH_CMP, OP_DIV_STEP,
    OP_PICK, OP_SLOT_RD, OP_CNT_WR, OP_DUP_RD, OP_SHIFT_RD, OP_SHIFT_WR, OP_INS
  } pcs_op_t;

  typedef enum logic [2:0] {
    RES_NONE, RES_CODE, RES_DUP, RES_INS, RES_CNT, RES_READ
  } pcs_res_t;

  typedef struct packed {
    pcs_op_t     op;
    pcs_res_t    res;
    pcs_status_t code;
    logic        ld;
    logic        push;
  } pcs_cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic       enable;
    logic       busy;
    logic       use_sym;
    logic       win_ok;
    logic       rd_ok;
    logic       srch_done;
    logic       found;
    logic       div_done;
    logic       q_ok;
    logic       dup;
    logic       full;
    logic       shift_done;
    logic       sweep_done;
  } pcs_stat_t;

endpackage

### src/pcs_datapath.sv
// Profiler datapath: slot memories, search, divider, totals and result.
module pcs_datapath (
  input  logic             clk,
  input  logic             rst_n,
  input  pcs_pkg::pcs_cfg_t cfg,
  input  pcs_pkg::pcs_in_t  in_data,
  input  pcs_pkg::pcs_cmd_t cmd,
  output pcs_pkg::pcs_stat_t st,
  output pcs_pkg::pcs_out_t  res
);
  import pcs_pkg::*;

  logic [CNT_W-1:0]  hit_mem [SLOT_DEPTH];
  logic [ADDR_W-1:0] sym_mem [SLOT_DEPTH];

  pcs_in_t           item_r;
  logic [31:0]       tot_r;
  logic [IDX_W-1:0]  held_r, lo_r, hi_r, ix_r, ptr_r;
  logic [31:0]       rem_r, dnd_r, quo_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [ADDR_W-1:0] baddr_r, sym_q;
  logic [CNT_W-1:0]  hit_q;
  pcs_status_t       rstat_r;
  logic [SLOT_W-1:0] rslot_r;
  logic [31:0]       rhits_r, raddr_r;

  logic [ADDR_W-1:0] samp, key, prod, slot_addr;
  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid, lo_m1, ptr_m1;
  logic [32:0]       rem_s, rem_d;
  logic              rem_ge, is_clear;
  logic [CNT_W-1:0]  cnt_sum;

  logic              hit_we, sym_we;
  logic [SLOT_W-1:0] hit_wa, hit_ra, sym_wa, sym_ra;
  logic [CNT_W-1:0]  hit_wd;
  logic [ADDR_W-1:0] sym_wd;

  // sampled address and search key
  assign samp      = cfg.sample_link ? item_r.sample_return : item_r.sample_pc;
  assign key       = (item_r.command == CMD_ADD) ? item_r.symbol_address : samp;
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[IDX_W:1];
  assign lo_m1     = lo_r - 1'b1;
  assign ptr_m1    = ptr_r - 1'b1;
  assign is_clear  = (item_r.command == CMD_CLR_CNT) || (item_r.command == CMD_CLR_SYM);
  assign cnt_sum   = hit_q + CNT_W'(item_r.tick_count);

  // one restoring division step
  assign rem_s  = {rem_r, dnd_r[31]};
  assign rem_ge = rem_s >= {1'b0, cfg.bucket_bytes};
  assign rem_d  = rem_s - {1'b0, cfg.bucket_bytes};

  // bucket start address
  assign prod      = ADDR_W'(ix_r) * cfg.bucket_bytes;
  assign slot_addr = cfg.use_symbols ? sym_q : baddr_r;

  // memory port selection
  always_comb begin
    hit_we = 1'b0;
    sym_we = 1'b0;
    hit_wa = ptr_r[SLOT_W-1:0];
    sym_wa = ptr_r[SLOT_W-1:0];
    hit_wd = '0;
    sym_wd = key;
    hit_ra = ix_r[SLOT_W-1:0];
    sym_ra = ix_r[SLOT_W-1:0];
    unique case (cmd.op)
      OP_SWEEP: hit_we = 1'b1;
      OP_SRCH_RD: sym_ra = mid[SLOT_W-1:0];
      OP_DUP_RD: begin
        hit_ra = lo_m1[SLOT_W-1:0];
        sym_ra = lo_m1[SLOT_W-1:0];
      end
      OP_SHIFT_RD: begin
        hit_ra = ptr_m1[SLOT_W-1:0];
        sym_ra = ptr_m1[SLOT_W-1:0];
      end
      OP_SHIFT_WR: begin
        hit_we = 1'b1;
        sym_we = 1'b1;
        hit_wd = hit_q;
        sym_wd = sym_q;
      end
      OP_INS: begin
        hit_we = 1'b1;
        sym_we = 1'b1;
        hit_wa = lo_r[SLOT_W-1:0];
        sym_wa = lo_r[SLOT_W-1:0];
      end
      OP_CNT_WR: begin
        hit_we = 1'b1;
        hit_wa = ix_r[SLOT_W-1:0];
        hit_wd = cnt_sum;
      end
      default: ;
    endcase
  end

  // hit counter memory
  always_ff @(posedge clk) begin
    if (hit_we) begin
      hit_mem[hit_wa] <= hit_wd;
    end
    hit_q <= hit_mem[hit_ra];
  end

  // symbol start memory
  always_ff @(posedge clk) begin
    if (sym_we) begin
      sym_mem[sym_wa] <= sym_wd;
    end
    sym_q <= sym_mem[sym_ra];
  end

  // control-like state: totals, table fill, sweep pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r  <= '0;
      held_r <= '0;
      ptr_r  <= '0;
    end else begin
      unique case (cmd.op)
        OP_DECODE: begin
          if (item_r.command == CMD_TICK && cfg.enable) begin
            tot_r <= tot_r + 32'(item_r.tick_count);
          end
          if (is_clear) begin
            tot_r <= '0;
          end
          if (item_r.command == CMD_CLR_SYM) begin
            held_r <= '0;
          end
          ptr_r <= is_clear ? '0 : held_r;
        end
        OP_SWEEP:    ptr_r  <= ptr_r + 1'b1;
        OP_SHIFT_WR: ptr_r  <= ptr_m1;
        OP_INS:      held_r <= held_r + 1'b1;
        default: ;
      endcase
    end
  end

  // item capture and working registers
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      item_r <= in_data;
    end
    unique case (cmd.op)
      OP_DECODE: begin
        lo_r   <= '0;
        hi_r   <= held_r;
        ix_r   <= IDX_W'(item_r.slot_index);
        rem_r  <= '0;
        dnd_r  <= samp - cfg.window_start;
        quo_r  <= '0;
        dcnt_r <= '0;
      end
      OP_SRCH_CMP: begin
        if (sym_q > key) begin
          hi_r <= mid;
        end else begin
          lo_r <= mid + 1'b1;
        end
      end
      OP_DIV_STEP: begin
        rem_r  <= rem_ge ? rem_d[31:0] : rem_s[31:0];
        quo_r  <= {quo_r[30:0], rem_ge};
        dnd_r  <= {dnd_r[30:0], 1'b0};
        dcnt_r <= dcnt_r + 1'b1;
      end
      OP_PICK:    ix_r    <= cfg.use_symbols ? lo_m1 : quo_r[IDX_W-1:0];
      OP_SLOT_RD: baddr_r <= cfg.window_start + prod;
      default: ;
    endcase
  end

  // result fields
  always_ff @(posedge clk) begin
    unique case (cmd.res)
      RES_CODE: begin
        rstat_r <= cmd.code;
        rslot_r <= '0;
        rhits_r <= '0;
        raddr_r <= '0;
      end
      RES_DUP: begin
        rstat_r <= ST_DUP;
        rslot_r <= lo_m1[SLOT_W-1:0];
        rhits_r <= hit_q;
        raddr_r <= key;
      end
      RES_INS: begin
        rstat_r <= ST_OK;
        rslot_r <= lo_r[SLOT_W-1:0];
        rhits_r <= '0;
        raddr_r <= key;
      end
      RES_CNT: begin
        rstat_r <= ST_OK;
        rslot_r <= ix_r[SLOT_W-1:0];
        rhits_r <= cnt_sum;
        raddr_r <= slot_addr;
      end
      RES_READ: begin
        rstat_r <= ST_OK;
        rslot_r <= ix_r[SLOT_W-1:0];
        rhits_r <= hit_q;
        raddr_r <= slot_addr;
      end
      default: ;
    endcase
  end

  assign res.status       = rstat_r;
  assign res.slot_used    = rslot_r;
  assign res.hit_value    = rhits_r;
  assign res.slot_address = raddr_r;
  assign res.total_ticks  = tot_r;
  assign res.symbol_count = held_r;

  // status toward the controller
  assign st.command    = item_r.command;
  assign st.enable     = cfg.enable;
  assign st.busy       = item_r.core_busy;
  assign st.use_sym    = cfg.use_symbols;
  assign st.win_ok     = (samp >= cfg.window_start) && (samp < cfg.window_end)
                         && (cfg.bucket_bytes != '0);
  assign st.rd_ok      = !cfg.use_symbols || (IDX_W'(item_r.slot_index) < held_r);
  assign st.srch_done  = lo_r >= hi_r;
  assign st.found      = lo_r != '0;
  assign st.div_done   = dcnt_r == DCNT_W'(DIV_STEPS);
  assign st.q_ok       = quo_r[31:SLOT_W] == '0;
  assign st.dup        = sym_q == key;
  assign st.full       = held_r == IDX_W'(SLOT_DEPTH);
  assign st.shift_done = ptr_r == lo_r;
  assign st.sweep_done = ptr_r == IDX_W'(SLOT_DEPTH);

endmodule

### src/pcs_ctrl.sv
// Profiler controller: sequences each command over the datapath.
`include "pc_sample_profiler_macros.svh"
module pcs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_free,
  input  pcs_pkg::pcs_stat_t st,
  output logic               in_ready,
  output pcs_pkg::pcs_cmd_t  cmd
);
  import pcs_pkg::*;

  pcs_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_INIT: if (st.sweep_done) state_nxt = S_IDLE;
      S_IDLE: if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        case (st.command)
          CMD_TICK: begin
            if (!st.enable || !st.busy) state_nxt = S_FIN;
            else if (st.use_sym)        state_nxt = S_SRCH;
            else if (st.win_ok)         state_nxt = S_DIV;
            else                        state_nxt = S_FIN;
          end
          CMD_ADD:     state_nxt = S_SRCH;
          CMD_CLR_CNT: state_nxt = S_CLR;
          CMD_CLR_SYM: state_nxt = S_CLR;
          CMD_READ:    state_nxt = st.rd_ok ? S_SLOT_RD : S_FIN;
          default:     state_nxt = S_FIN;
        endcase
      end
      S_SRCH: begin
        if (!st.srch_done)             state_nxt = S_SRCH_CMP;
        else if (st.command == CMD_TICK) state_nxt = st.found ? S_CNT_RD : S_FIN;
        else if (st.found)             state_nxt = S_DUP_RD;
        else                           state_nxt = st.full ? S_FIN : S_SHIFT;
      end
      S_SRCH_CMP: state_nxt = S_SRCH;
      S_DIV: begin
        if (st.div_done) state_nxt = st.q_ok ? S_CNT_RD : S_FIN;
      end
      S_CNT_RD:   state_nxt = S_CNT_WR;
      S_CNT_WR:   state_nxt = S_FIN;
      S_SLOT_RD:  state_nxt = S_SLOT_FIN;
      S_SLOT_FIN: state_nxt = S_FIN;
      S_DUP_RD:   state_nxt = S_DUP_CMP;
      S_DUP_CMP:  state_nxt = (st.dup || st.full) ? S_FIN : S_SHIFT;
      S_SHIFT:    state_nxt = st.shift_done ? S_INS : S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT;
      S_INS:      state_nxt = S_FIN;
      S_CLR:      if (st.sweep_done) state_nxt = S_FIN;
      S_FIN:      if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    in_ready = 1'b0;
    cmd.op   = OP_NONE;
    cmd.res  = RES_NONE;
    cmd.code = ST_OK;
    cmd.ld   = 1'b0;
    cmd.push = 1'b0;
    unique case (state_r)
      S_INIT: if (!st.sweep_done) cmd.op = OP_SWEEP;
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.ld   = in_valid;
      end
      S_DECODE: begin
        cmd.op = OP_DECODE;
        case (st.command)
          CMD_TICK: begin
            if (!st.enable || !st.busy) begin
              cmd.res  = RES_CODE;
              cmd.code = ST_IGNORED;
            end else if (!st.use_sym && !st.win_ok) begin
              cmd.res  = RES_CODE;
              cmd.code = ST_RANGE;
            end
          end
          CMD_ADD, CMD_CLR_CNT, CMD_CLR_SYM: ;
          CMD_READ: begin
            if (!st.rd_ok) begin
              cmd.res  = RES_CODE;
              cmd.code = ST_RANGE;
            end
          end
          default: begin
            cmd.res  = RES_CODE;
            cmd.code = ST_IGNORED;
          end
        endcase
      end
      S_SRCH: begin
        if (!st.srch_done) begin
          cmd.op = OP_SRCH_RD;
        end else if (st.command == CMD_TICK) begin
          if (st.found) begin
            cmd.op = OP_PICK;
          end else begin
            cmd.res  = RES_CODE;
            cmd.code = ST_RANGE;
          end
        end else if (!st.found && st.full) begin
          cmd.res  = RES_CODE;
          cmd.code = ST_FULL;
        end
      end
      S_SRCH_CMP: cmd.op = OP_SRCH_CMP;
      S_DIV: begin
        if (!st.div_done) begin
          cmd.op = OP_DIV_STEP;
        end else if (st.q_ok) begin
          cmd.op = OP_PICK;
        end else begin
          cmd.res  = RES_CODE;
          cmd.code = ST_RANGE;
        end
      end
      S_CNT_RD, S_SLOT_RD: cmd.op = OP_SLOT_RD;
      S_CNT_WR: begin
        cmd.op  = OP_CNT_WR;
        cmd.res = RES_CNT;
      end
      S_SLOT_FIN: cmd.res = RES_READ;
      S_DUP_RD:   cmd.op  = OP_DUP_RD;
      S_DUP_CMP: begin
        if (st.dup) begin
          cmd.res = RES_DUP;
        end else if (st.full) begin
          cmd.res  = RES_CODE;
          cmd.code = ST_FULL;
        end
      end
      S_SHIFT:    if (!st.shift_done) cmd.op = OP_SHIFT_RD;
      S_SHIFT_WR: cmd.op = OP_SHIFT_WR;
      S_INS: begin
        cmd.op  = OP_INS;
        cmd.res = RES_INS;
      end
      S_CLR: begin
        if (!st.sweep_done) begin
          cmd.op = OP_SWEEP;
        end else begin
          cmd.res  = RES_CODE;
          cmd.code = ST_OK;
        end
      end
      S_FIN:   cmd.push = out_free;
      default: ;
    endcase
  end

  `PCS_ASSERT_NEXT(a_accept_decode, in_valid && in_ready, state_r == S_DECODE, "accepted beat not decoded")
  `PCS_ASSERT_NOW(a_fin_quiet, state_r == S_FIN, cmd.op == OP_NONE, "datapath op while holding result")
  `PCS_ASSERT_NEXT(a_srch_pair, (state_r == S_SRCH) && !st.srch_done, state_r == S_SRCH_CMP, "search probe not compared")

endmodule

### src/pc_sample_profiler.sv
// Top level of the pc sample profiler: register port, output stage, core.
//
//  channel  | ports                      | beat
//  ---------+----------------------------+------------------------------
//  input    | in_valid/in_ready/in_data  | one command
//  result   | out_valid/out_ready/out_data | one result per command
//  config   | psel/penable/pwrite/paddr  | one register write or read
//
// One command at a time. Tick in bucket mode runs a 32-step divider.
// Tick in symbol mode runs a binary search; each probe is a read state then a compare state.
// Add symbol: search, then each entry at or above the insert point moves up one slot.
// Clear commands sweep the hit counter memory.
// After reset a sweep zeroes all 1024 counters with in_ready low.
// A result waiting on out_ready holds the next command in its last state.
module pc_sample_profiler (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pcs_pkg::pcs_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output pcs_pkg::pcs_out_t         out_data,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pcs_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import pcs_pkg::*;

  pcs_cfg_t  cfg_r;
  pcs_out_t  out_r;
  logic      out_valid_r;
  pcs_cmd_t  cmd;
  pcs_stat_t st;
  pcs_out_t  res;
  logic      out_free, wr_en;
  pcs_reg_t  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = pcs_reg_t'(paddr[4:2]);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable       <= 1'b0;
      cfg_r.sample_link  <= 1'b0;
      cfg_r.use_symbols  <= 1'b0;
      cfg_r.window_start <= '0;
      cfg_r.window_end   <= '0;
      cfg_r.bucket_bytes <= 32'd4;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ENABLE:  cfg_r.enable       <= pwdata[0];
        REG_LINK:    cfg_r.sample_link  <= pwdata[0];
        REG_USE_SYM: cfg_r.use_symbols  <= pwdata[0];
        REG_WSTART:  cfg_r.window_start <= pwdata;
        REG_WEND:    cfg_r.window_end   <= pwdata;
        REG_BUCKET:  cfg_r.bucket_bytes <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_ENABLE:  prdata = {31'b0, cfg_r.enable};
      REG_LINK:    prdata = {31'b0, cfg_r.sample_link};
      REG_USE_SYM: prdata = {31'b0, cfg_r.use_symbols};
      REG_WSTART:  prdata = cfg_r.window_start;
      REG_WEND:    prdata = cfg_r.window_end;
      REG_BUCKET:  prdata = cfg_r.bucket_bytes;
      default:     prdata = '0;
    endcase
  end

  // output register
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  pcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .st       (st),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  pcs_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_data (in_data),
    .cmd     (cmd),
    .st      (st),
    .res     (res)
  );

endmodule

### verif/testbench.sv
// Self-checking testbench for the pc sample profiler: directed and random commands.
`timescale 1ns / 100ps

module testbench;
  import pcs_pkg::*;

  localparam int WATCHDOG_CYCLES = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  pcs_in_t     in_data;
  logic        out_valid;
  logic        out_ready;
  pcs_out_t    out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pc_sample_profiler u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Predicted profiler state
  logic [31:0] prof_hits [SLOT_DEPTH];
  logic [31:0] prof_syms [SLOT_DEPTH];
  int unsigned prof_nsym;
  logic [31:0] prof_total;
  pcs_cfg_t    prof_cfg;

  pcs_out_t    result_queue[$];
  int          mismatches;
  bit          timed_out;
  int          idle_pct;     // idle chance in percent, both sides
  bit          hold_results;
  int          quiet_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // First entry strictly greater than addr
  function automatic int unsigned sym_upper(logic [31:0] addr);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = prof_nsym;
    while (hi > lo) begin
      mid = (lo + hi) >> 1;
      if (prof_syms[mid] > addr) hi = mid;
      else lo = mid + 1;
    end
    return lo;
  endfunction

  function automatic logic [31:0] slot_start(int unsigned ix);
    logic [63:0] a;
    if (prof_cfg.use_symbols) return prof_syms[ix];
    a = 64'(prof_cfg.window_start) + 64'(ix) * 64'(prof_cfg.bucket_bytes);
    return a[31:0];
  endfunction

  // Predict result of one command and update state
  function automatic pcs_out_t profile_step(pcs_in_t c);
    pcs_out_t r;
    logic [31:0] pc;
    logic [63:0] q;
    int unsigned ix;
    bit ok;
    r = '0;
    r.status = ST_IGNORED;
    ok = 0;
    ix = 0;
    case (c.command)
      CMD_TICK: begin
        if (prof_cfg.enable) begin
          prof_total = prof_total + 32'(c.tick_count);
          if (c.core_busy) begin
            pc = prof_cfg.sample_link ? c.sample_return : c.sample_pc;
            if (prof_cfg.use_symbols) begin
              ix = sym_upper(pc);
              if (ix > 0) begin ix = ix - 1; ok = 1; end
            end else if (pc >= prof_cfg.window_start && pc < prof_cfg.window_end &&
                         prof_cfg.bucket_bytes != 0) begin
              q = 64'(pc - prof_cfg.window_start) / 64'(prof_cfg.bucket_bytes);
              if (q < SLOT_DEPTH) begin ix = int'(q); ok = 1; end
            end
            if (ok) begin
              prof_hits[ix] = prof_hits[ix] + 32'(c.tick_count);
              r.status = ST_OK;
              r.slot_used = ix[SLOT_W-1:0];
              r.hit_value = prof_hits[ix];
              r.slot_address = slot_start(ix);
            end else begin
              r.status = ST_RANGE;
            end
          end
        end
      end
      CMD_ADD: begin
        ix = sym_upper(c.symbol_address);
        if (ix > 0 && prof_syms[ix-1] == c.symbol_address) begin
          r.status = ST_DUP;
          r.slot_used = SLOT_W'(ix - 1);
          r.hit_value = prof_hits[ix-1];
          r.slot_address = c.symbol_address;
        end else if (prof_nsym >= SLOT_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = int'(prof_nsym); i > int'(ix); i--) begin
            prof_syms[i] = prof_syms[i-1];
            prof_hits[i] = prof_hits[i-1];
          end
          prof_syms[ix] = c.symbol_address;
          prof_hits[ix] = '0;
          prof_nsym++;
          r.status = ST_OK;
          r.slot_used = ix[SLOT_W-1:0];
          r.slot_address = c.symbol_address;
        end
      end
      CMD_CLR_CNT, CMD_CLR_SYM: begin
        foreach (prof_hits[i]) prof_hits[i] = '0;
        prof_total = '0;
        if (c.command == CMD_CLR_SYM) prof_nsym = 0;
        r.status = ST_OK;
      end
      CMD_READ: begin
        ix = c.slot_index;
        if (prof_cfg.use_symbols && ix >= prof_nsym) begin
          r.status = ST_RANGE;
        end else begin
          r.status = ST_OK;
          r.slot_used = c.slot_index;
          r.hit_value = prof_hits[ix];
          r.slot_address = slot_start(ix);
        end
      end
      default: ;
    endcase
    r.total_ticks = prof_total;
    r.symbol_count = IDX_W'(prof_nsym);
    return r;
  endfunction

  // Send one command beat and record its prediction
  task automatic send_cmd(pcs_in_t c);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    result_queue.push_back(profile_step(c));
  endtask

  // Register write: setup then access
  task automatic write_reg(pcs_reg_t idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_ENABLE:  prof_cfg.enable = val[0];
      REG_LINK:    prof_cfg.sample_link = val[0];
      REG_USE_SYM: prof_cfg.use_symbols = val[0];
      REG_WSTART:  prof_cfg.window_start = val;
      REG_WEND:    prof_cfg.window_end = val;
      REG_BUCKET:  prof_cfg.bucket_bytes = val;
      default: ;
    endcase
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (result_queue.size() > 0 && !timed_out) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_mode(bit en, bit link, bit sym, logic [31:0] ws, logic [31:0] we,
                          logic [31:0] bb);
    drain();
    write_reg(REG_ENABLE, 32'(en));
    write_reg(REG_LINK, 32'(link));
    write_reg(REG_USE_SYM, 32'(sym));
    write_reg(REG_WSTART, ws);
    write_reg(REG_WEND, we);
    write_reg(REG_BUCKET, bb);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic pcs_in_t mk_cmd(logic [2:0] code);
    pcs_in_t c;
    c.command        = code;
    c.sample_pc      = $urandom;
    c.sample_return  = $urandom;
    c.tick_count     = 8'($urandom);
    c.core_busy      = 1'b1;
    c.symbol_address = $urandom;
    c.slot_index     = SLOT_W'($urandom);
    return c;
  endfunction

  // Result checker
  always @(posedge clk) begin
    pcs_out_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (result_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        exp_r = result_queue.pop_front();
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", exp_r, out_data);
        end
      end
    end
  end

  // Receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_results && !(idle_pct > 0 && $urandom_range(99) < idle_pct);
  end

  // Watchdog on accepted beats
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_CYCLES && !timed_out) begin
      timed_out = 1;
      $display("** pc_sample_profiler: FAILED **");
      $finish;
    end
  end

  // Directed: fields at extremes, every command and special case
  task automatic test_directed;
    pcs_in_t c;
    c = mk_cmd(CMD_TICK); send_cmd(c);               // disabled tick
    set_mode(1, 0, 0, 32'h1000, 32'h2000, 4);
    c = mk_cmd(CMD_TICK); c.sample_pc = 32'h1000; c.tick_count = 8'hff; send_cmd(c);
    c = mk_cmd(CMD_TICK); c.sample_pc = 32'h1ffc; send_cmd(c);
    c = mk_cmd(CMD_TICK); c.sample_pc = 32'h2000; send_cmd(c);     // past window
    c = mk_cmd(CMD_TICK); c.sample_pc = 32'h0; send_cmd(c);
    c = mk_cmd(CMD_TICK); c.core_busy = 0; send_cmd(c);           // idle tick
    c = mk_cmd(CMD_READ); c.slot_index = 0; send_cmd(c);
    c = mk_cmd(CMD_READ); c.slot_index = 10'h3ff; send_cmd(c);
    c = mk_cmd(3'd5); send_cmd(c);
    c = mk_cmd(3'd7); send_cmd(c);
    c = mk_cmd(CMD_CLR_CNT); send_cmd(c);
    // bucket index past the slot count, zero bucket size, link sampling
    set_mode(1, 1, 0, 32'h0, 32'hffff_ffff, 4);
    c = mk_cmd(CMD_TICK); c.sample_return = 32'hffff_fff0; send_cmd(c);
    c = mk_cmd(CMD_TICK); c.sample_return = 32'h0ffc; send_cmd(c);
    set_mode(1, 1, 0, 32'h0, 32'hffff_ffff, 0);
    c = mk_cmd(CMD_TICK); send_cmd(c);
    set_mode(1, 0, 1, 32'h0, 32'h0, 32'h8000_0000);
    c = mk_cmd(CMD_TICK); send_cmd(c);                            // empty table
    c = mk_cmd(CMD_ADD); c.symbol_address = 32'h8000; send_cmd(c);
    c = mk_cmd(CMD_ADD); c.symbol_address = 32'h0; send_cmd(c);
    c = mk_cmd(CMD_ADD); c.symbol_address = 32'hffff_ffff; send_cmd(c);
    c = mk_cmd(CMD_ADD); c.symbol_address = 32'h8000; send_cmd(c); // duplicate
    c = mk_cmd(CMD_TICK); c.sample_pc = 32'hffff_ffff; send_cmd(c); // last symbol
    c = mk_cmd(CMD_TICK); c.sample_pc = 32'h8004; send_cmd(c);
    c = mk_cmd(CMD_READ); c.slot_index = 3; send_cmd(c);
    c = mk_cmd(CMD_CLR_SYM); send_cmd(c);
  endtask

  // Fill the symbol table to its limit, then hit it with a full insert
  task automatic test_full_table;
    pcs_in_t c;
    set_mode(1, 0, 1, 0, 0, 4);
    for (int i = 0; i < SLOT_DEPTH; i++) begin
      c = mk_cmd(CMD_ADD);
      c.symbol_address = 32'(i) << 12;
      send_cmd(c);
    end
    c = mk_cmd(CMD_ADD); c.symbol_address = 32'h123; send_cmd(c);
    c = mk_cmd(CMD_ADD); c.symbol_address = 32'h5000; send_cmd(c);
    c = mk_cmd(CMD_READ); c.slot_index = 10'h3ff; send_cmd(c);
    c = mk_cmd(CMD_CLR_SYM); send_cmd(c);
  endtask

  // Random commands; most are ticks aimed into bins
  task automatic test_random(int n, bit sym);
    pcs_in_t c;
    int unsigned k;
    set_mode($urandom_range(9) != 0, $urandom_range(1), sym,
             32'h4000_0000 + ($urandom & 32'hffc), 32'h4001_0000, 4 << $urandom_range(6));
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      c = mk_cmd(k < 60 ? CMD_TICK : k < 80 ? CMD_ADD : k < 92 ? CMD_READ :
                 k < 94 ? CMD_CLR_CNT : k < 95 ? CMD_CLR_SYM : 3'($urandom_range(5, 7)));
      if ($urandom_range(3) != 0) begin
        c.sample_pc      = 32'h4000_0000 + ($urandom & 32'h1_ffff);
        c.sample_return  = 32'h4000_0000 + ($urandom & 32'h1_ffff);
        c.symbol_address = 32'h4000_0000 + ($urandom & 32'h1_fff0);
        c.slot_index     = SLOT_W'($urandom_range(40));
      end
      c.core_busy = $urandom_range(7) != 0;
      send_cmd(c);
    end
  endtask

  // Receiver holds off while commands keep coming
  task automatic test_backpressure;
    drain();
    hold_results = 1;
    fork
      begin repeat (300) @(posedge clk); hold_results = 0; end
      test_random(20, 0);
    join
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0; timed_out = 0; hold_results = 0; idle_pct = 11;
    foreach (prof_hits[i]) begin prof_hits[i] = '0; prof_syms[i] = '0; end
    prof_nsym = 0; prof_total = '0;
    prof_cfg = '0; prof_cfg.bucket_bytes = 32'd4;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    idle_pct = 0;
    test_full_table();
    idle_pct = 11;
    test_backpressure();
    test_random(30, 0);
    test_random(30, 1);
    drain();
    if (mismatches == 0 && result_queue.size() == 0)
      $display("** pc_sample_profiler: PASSED **");
    else
      $display("** pc_sample_profiler: FAILED **");
    $finish;
  end

endmodule
